/* rtl/core/sssp_pkg.sv */
// Shared types and constants of the shortest path block.
// No dependencies.
package sssp_pkg;

   localparam int NODE_BITS = 6;
   localparam int DIST_BITS = 21;
   localparam int DEF_MAX_NODES = 64;
   localparam int DEF_MAX_EDGES = 256;
   localparam int DEF_WEIGHT_BITS = 16;
   localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};

   localparam logic [0:0] REG_NODE_COUNT = 1'b0;
   localparam logic [0:0] REG_START_NODE = 1'b1;

   typedef struct packed {
      logic [NODE_BITS-1:0] edge_from;
      logic [NODE_BITS-1:0] edge_to;
      logic signed [DEF_WEIGHT_BITS-1:0] edge_weight;
      logic last_edge;
   } req_type;

   typedef struct packed {
      logic [NODE_BITS-1:0] node_index;
      logic [DIST_BITS-1:0] path_length;
      logic reached;
      logic [NODE_BITS-1:0] tree_parent;
      logic neg_weight_error;
      logic last_result;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // store the presented edge
      logic init;        // write start values of node at node index
      logic scan_start;  // clear running minimum
      logic node_rd;     // read node tables at node index
      logic scan_step;   // compare node read last cycle
      logic fin;         // finalise chosen node
      logic edge_rd;     // issue edge read
      logic dist_rd;     // read distance of edge destination
      logic relax;       // relax edge against distance read last cycle
      logic out_load;    // capture result for node
      logic out_err;     // capture error result
      logic clear;       // empty edge store
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic found;       // a node was selected by the scan
      logic neg_seen;
      logic edge_hit;    // edge read leaves chosen node, lands in range
   } sts_type;

endpackage

/* rtl/core/sssp_ctrl.sv */
// Controller state machine of the shortest path block.
// Depends on sssp_pkg.
module sssp_ctrl #(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 256
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_last,
   input  logic rsp_free,
   input  logic [$clog2(MAX_NODES+1)-1:0] n_use,
   input  logic [$clog2(MAX_EDGES+1)-1:0] edge_cnt,
   input  sssp_pkg::sts_type sts,
   output sssp_pkg::cmd_type cmd,
   output logic [$clog2(MAX_NODES)-1:0] node_idx,
   output logic [$clog2(MAX_EDGES)-1:0] edge_idx,
   output logic out_last
);
   import sssp_pkg::*;

   localparam int NB = $clog2(MAX_NODES);
   localparam int EB = $clog2(MAX_EDGES);
   localparam int NCB = $clog2(MAX_NODES+1);
   localparam int ECB = $clog2(MAX_EDGES+1);

   typedef enum logic [9:0] {
      S_LOAD  = 10'b00_0000_0001,
      S_INIT  = 10'b00_0000_0010,
      S_SCAN  = 10'b00_0000_0100,
      S_PICK  = 10'b00_0000_1000,
      S_EDGE  = 10'b00_0001_0000,
      S_EDEC  = 10'b00_0010_0000,
      S_RELAX = 10'b00_0100_0000,
      S_ORD   = 10'b00_1000_0000,
      S_OUT   = 10'b01_0000_0000,
      S_ERR   = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [NCB-1:0] ncnt_ff, ncnt_in;
   logic [ECB-1:0] ecnt_ff, ecnt_in;
   logic edges_done;

   assign node_idx = ncnt_ff[NB-1:0];
   assign edge_idx = ecnt_ff[EB-1:0];
   assign out_last = (ncnt_ff + NCB'(1)) == n_use;
   assign req_ready = (state_ff == S_LOAD);
   assign edges_done = (ecnt_ff + ECB'(1)) == edge_cnt;

   always_comb begin
      state_in = state_ff;
      ncnt_in = ncnt_ff;
      ecnt_in = ecnt_ff;
      cmd = '0;
      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = S_INIT;
                  ncnt_in = '0;
               end
            end
         end
         S_INIT: begin
            if (sts.neg_seen) begin
               state_in = S_ERR;
            end else begin
               cmd.init = 1'b1;
               ncnt_in = ncnt_ff + NCB'(1);
               if (ncnt_ff + NCB'(1) == n_use) begin
                  state_in = S_SCAN;
                  cmd.scan_start = 1'b1;
                  ncnt_in = '0;
               end
            end
         end
         S_SCAN: begin
            // each compare uses the node read in the previous cycle
            cmd.node_rd = (ncnt_ff != n_use);
            cmd.scan_step = (ncnt_ff != '0);
            if (ncnt_ff == n_use) begin
               state_in = S_PICK;
            end else begin
               ncnt_in = ncnt_ff + NCB'(1);
            end
         end
         S_PICK: begin
            if (sts.found) begin
               cmd.fin = 1'b1;
               ecnt_in = '0;
               ncnt_in = '0;
               state_in = (edge_cnt == '0) ? S_SCAN : S_EDGE;
               cmd.scan_start = (edge_cnt == '0);
            end else begin
               ncnt_in = '0;
               state_in = S_ORD;
            end
         end
         S_EDGE: begin
            cmd.edge_rd = 1'b1;
            state_in = S_EDEC;
         end
         S_EDEC: begin
            if (sts.edge_hit) begin
               cmd.dist_rd = 1'b1;
               state_in = S_RELAX;
            end else begin
               ecnt_in = ecnt_ff + ECB'(1);
               if (edges_done) begin
                  cmd.scan_start = 1'b1;
                  ncnt_in = '0;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_EDGE;
               end
            end
         end
         S_RELAX: begin
            cmd.relax = 1'b1;
            ecnt_in = ecnt_ff + ECB'(1);
            if (edges_done) begin
               cmd.scan_start = 1'b1;
               ncnt_in = '0;
               state_in = S_SCAN;
            end else begin
               state_in = S_EDGE;
            end
         end
         S_ORD: begin
            cmd.node_rd = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_free) begin
               cmd.out_load = 1'b1;
               ncnt_in = ncnt_ff + NCB'(1);
               if (out_last) begin
                  cmd.clear = 1'b1;
                  state_in = S_LOAD;
               end else begin
                  state_in = S_ORD;
               end
            end
         end
         S_ERR: begin
            if (rsp_free) begin
               cmd.out_err = 1'b1;
               cmd.clear = 1'b1;
               state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         ncnt_ff <= '0;
         ecnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         ncnt_ff <= ncnt_in;
         ecnt_ff <= ecnt_in;
      end
   end

endmodule

/* rtl/core/sssp_dpath.sv */
// Datapath of the shortest path block: edge store, node tables, min scan, relax.
// Depends on sssp_pkg.
module sssp_dpath #(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 256
) (
   input  logic clock,
   input  logic reset,
   input  sssp_pkg::cmd_type cmd,
   input  sssp_pkg::req_type req,
   input  logic [$clog2(MAX_NODES+1)-1:0] n_use,
   input  logic [sssp_pkg::NODE_BITS-1:0] start_node,
   input  logic [$clog2(MAX_NODES)-1:0] node_idx,
   input  logic [$clog2(MAX_EDGES)-1:0] edge_idx,
   input  logic out_last,
   output logic [$clog2(MAX_EDGES+1)-1:0] edge_cnt,
   output sssp_pkg::sts_type sts,
   output sssp_pkg::rsp_type res
);
   import sssp_pkg::*;

   localparam int NB = $clog2(MAX_NODES);
   localparam int EB = $clog2(MAX_EDGES);
   localparam int ECB = $clog2(MAX_EDGES+1);
   localparam int WB = DEF_WEIGHT_BITS - 1;
   localparam int SB = (DIST_BITS > WB ? DIST_BITS : WB) + 1;

   // edge memory: src, dst, weight magnitude
   logic [2*NODE_BITS+WB-1:0] emem [MAX_EDGES];
   logic [2*NODE_BITS+WB-1:0] erd_ff;
   logic [ECB-1:0] ecnt_ff;
   logic neg_ff;

   // node tables, registered read
   logic [DIST_BITS-1:0] dist_mem [MAX_NODES];
   logic [NODE_BITS-1:0] par_mem [MAX_NODES];
   logic [DIST_BITS-1:0] drd_ff;
   logic [NODE_BITS-1:0] prd_ff;
   logic fin_rd_ff;
   logic [NB-1:0] ridx_ff;
   logic [MAX_NODES-1:0] fin_ff;

   logic [DIST_BITS-1:0] min_ff;
   logic [NB-1:0] minix_ff;
   logic found_ff;
   logic [DIST_BITS-1:0] du_ff;
   logic [NB-1:0] u_ff;

   logic [NODE_BITS-1:0] e_src, e_dst;
   logic [WB-1:0] e_w;
   logic [SB-1:0] cand_sum;
   logic [DIST_BITS-1:0] cand;
   logic e_hit;
   logic scan_hit;
   logic rd_hit;

   assign edge_cnt = ecnt_ff;
   assign sts.found = found_ff;
   assign sts.neg_seen = neg_ff;
   assign sts.edge_hit = e_hit;

   always_ff @(posedge clock) begin
      if (cmd.load && !req.edge_weight[DEF_WEIGHT_BITS-1] && ecnt_ff < ECB'(MAX_EDGES)) begin
         emem[ecnt_ff[EB-1:0]] <= {req.edge_from, req.edge_to, req.edge_weight[WB-1:0]};
      end
      if (cmd.edge_rd) begin
         erd_ff <= emem[edge_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ecnt_ff <= '0;
         neg_ff <= 1'b0;
      end else if (cmd.clear) begin
         ecnt_ff <= '0;
         neg_ff <= 1'b0;
      end else if (cmd.load) begin
         if (req.edge_weight[DEF_WEIGHT_BITS-1]) begin
            neg_ff <= 1'b1;
         end else if (ecnt_ff < ECB'(MAX_EDGES)) begin
            ecnt_ff <= ecnt_ff + ECB'(1);
         end
      end
   end

   assign {e_src, e_dst, e_w} = erd_ff;
   assign cand_sum = SB'(du_ff) + SB'(e_w);
   assign cand = (cand_sum > SB'(DIST_INF - 1'b1)) ? DIST_INF - 1'b1
                                                    : cand_sum[DIST_BITS-1:0];
   assign e_hit = (e_src == NODE_BITS'(u_ff))
                  && ((NODE_BITS+1)'(e_dst) < (NODE_BITS+1)'(n_use));
   assign scan_hit = cmd.scan_step && !fin_rd_ff && drd_ff < min_ff;
   assign rd_hit = (drd_ff != DIST_INF);

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         dist_mem[node_idx] <= (NODE_BITS'(node_idx) == start_node) ? '0 : DIST_INF;
         par_mem[node_idx] <= (NODE_BITS'(node_idx) == start_node) ? start_node : '0;
      end else if (cmd.relax && cand < drd_ff) begin
         dist_mem[e_dst[NB-1:0]] <= cand;
         par_mem[e_dst[NB-1:0]] <= NODE_BITS'(u_ff);
      end
      if (cmd.node_rd) begin
         drd_ff <= dist_mem[node_idx];
         prd_ff <= par_mem[node_idx];
         fin_rd_ff <= fin_ff[node_idx];
         ridx_ff <= node_idx;
      end else if (cmd.dist_rd) begin
         drd_ff <= dist_mem[e_dst[NB-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.init) begin
            fin_ff[node_idx] <= 1'b0;
         end else if (cmd.fin) begin
            fin_ff[minix_ff] <= 1'b1;
         end
         if (cmd.scan_start) begin
            found_ff <= 1'b0;
         end else if (scan_hit) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         min_ff <= DIST_INF;
      end else if (scan_hit) begin
         min_ff <= drd_ff;
         minix_ff <= ridx_ff;
      end
      if (cmd.fin) begin
         du_ff <= min_ff;
         u_ff <= minix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_err) begin
         res <= '{node_index: '0, path_length: '0, reached: 1'b0, tree_parent: '0,
                  neg_weight_error: 1'b1, last_result: 1'b1};
      end else if (cmd.out_load) begin
         res.node_index <= NODE_BITS'(node_idx);
         res.path_length <= rd_hit ? drd_ff : '0;
         res.reached <= rd_hit;
         res.tree_parent <= rd_hit ? prd_ff : '0;
         res.neg_weight_error <= 1'b0;
         res.last_result <= out_last;
      end
   end

endmodule

/* rtl/core/single_source_shortest_path_top.sv */
// Single-source shortest path block: top level.
// Joins sssp_ctrl and sssp_dpath, holds the CSR port; depends on sssp_pkg.
//
// Use: edges stream in on req_ (valid/ready), one transaction per cycle while
// loading. A transaction with last_edge set is stored, then the search runs:
// a clearing pass over the node tables, then per finalised node one scan over
// the N nodes, a pick step and a pass over the E stored edges (read and check
// per edge, plus a relax step where the edge leaves the chosen node and lands
// in range), and a last scan plus pick that finds nothing. Then one rsp_
// transaction per node in index order, each node's tables read before its
// result is loaded once the output register is free; last_result marks the end.
// A negative weight anywhere in the graph gives a single error transaction
// instead, loaded once the output register is free.
// req_ready is low from the last edge until the final result is loaded.
// A stalled receiver holds rsp_ payload and pauses the output walk.
// Edge store is a single-port memory; full store drops further edges.
// Reset (synchronous, active high) empties the edge store, node_count = 64,
// start_node = 0. CSRs: 0x0 node_count, 0x4 start_node; write only when idle.
// Node count 0 acts as 1, above MAX_NODES as MAX_NODES.
module single_source_shortest_path_top #(
   parameter int MAX_NODES = sssp_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES = sssp_pkg::DEF_MAX_EDGES
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  sssp_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output sssp_pkg::rsp_type rsp_data,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [2:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import sssp_pkg::*;

   localparam int NCB = $clog2(MAX_NODES+1);
   localparam int NB = $clog2(MAX_NODES);
   localparam int EB = $clog2(MAX_EDGES);
   localparam int ECB = $clog2(MAX_EDGES+1);

   logic [6:0] ncount_ff;
   logic [NODE_BITS-1:0] start_ff;
   logic [NCB-1:0] n_use;
   logic wr_en;

   cmd_type cmd;
   sts_type sts;
   rsp_type res;
   logic [NB-1:0] node_idx;
   logic [EB-1:0] edge_idx;
   logic [ECB-1:0] edge_cnt;
   logic out_last;
   logic rsp_valid_ff;
   logic rsp_free;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ncount_ff <= 7'd64;
         start_ff <= '0;
      end else if (wr_en && csr_paddr[2] == REG_NODE_COUNT && csr_paddr[1:0] == 2'b00) begin
         ncount_ff <= csr_pwdata[6:0];
      end else if (wr_en && csr_paddr[2] == REG_START_NODE && csr_paddr[1:0] == 2'b00) begin
         start_ff <= csr_pwdata[NODE_BITS-1:0];
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_NODE_COUNT: csr_prdata = {25'd0, ncount_ff};
         REG_START_NODE: csr_prdata = {26'd0, start_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // effective node count, clamped to 1..MAX_NODES
   always_comb begin
      if (ncount_ff == '0) begin
         n_use = NCB'(1);
      end else if (ncount_ff > 7'(MAX_NODES)) begin
         n_use = NCB'(MAX_NODES);
      end else begin
         n_use = NCB'(ncount_ff);
      end
   end

   // output register is free when empty or being taken
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load || cmd.out_err) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = res;

   sssp_ctrl #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_last(req_data.last_edge),
      .rsp_free(rsp_free), .n_use(n_use), .edge_cnt(edge_cnt), .sts(sts),
      .cmd(cmd), .node_idx(node_idx), .edge_idx(edge_idx), .out_last(out_last)
   );

   sssp_dpath #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .req(req_data),
      .n_use(n_use), .start_node(start_ff), .node_idx(node_idx),
      .edge_idx(edge_idx), .out_last(out_last), .edge_cnt(edge_cnt),
      .sts(sts), .res(res)
   );

   // a stalled result transaction holds valid and payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.out_err |=> rsp_valid && rsp_data.last_result && rsp_data.neg_weight_error)
      else $error("bad error result");

   a_out_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load || cmd.out_err) |-> rsp_free)
      else $error("result overwritten");

endmodule

/* tb/sv/tb_single_source_shortest_path_top.sv */
// Self-checking testbench for single_source_shortest_path_top.
// Streams edge graphs over req_, predicts per-node results, checks rsp_ transactions.
// Depends on sssp_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_single_source_shortest_path_top;
   import sssp_pkg::*;

   localparam int NODES_MAX = 64;
   localparam int EDGES_MAX = 256;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   single_source_shortest_path_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #10 clock = ~clock;

   // Shadow of the block: edge list, error flag and the two registers.
   logic [5:0]  graph_src[EDGES_MAX];
   logic [5:0]  graph_dst[EDGES_MAX];
   logic [20:0] graph_wt[EDGES_MAX];
   int          graph_edges = 0;
   bit          graph_neg = 0;
   logic [6:0]  cfg_nodes = 7'd64;
   logic [5:0]  cfg_start = 6'd0;

   rsp_type expected_paths[$];
   int errors = 0;
   int results_seen = 0;
   int runs_done = 0;
   int error_runs = 0;

   task automatic report_mismatch(input string what);
      errors++;
      $display("MISMATCH @%0t: %s", $time, what);
   endtask

   // Dijkstra with a minimum scan, edges relaxed in load order.
   task automatic predict_paths();
      logic [20:0] dist_tab[NODES_MAX];
      bit          done[NODES_MAX];
      logic [5:0]  par[NODES_MAX];
      int n, u;
      logic [20:0] du;
      logic [21:0] cand;
      rsp_type r;
      n = (cfg_nodes == 0) ? 1 : (cfg_nodes > NODES_MAX) ? NODES_MAX : cfg_nodes;
      for (int i = 0; i < NODES_MAX; i++) begin
         dist_tab[i] = DIST_INF;
         done[i] = 0;
         par[i] = '0;
      end
      if (cfg_start < n) begin
         dist_tab[cfg_start] = '0;
         par[cfg_start] = cfg_start;
      end
      forever begin
         u = n;
         du = DIST_INF;
         for (int i = 0; i < n; i++)
            if (!done[i] && dist_tab[i] < du) begin
               du = dist_tab[i];
               u = i;
            end
         if (u >= n) break;
         done[u] = 1;
         for (int e = 0; e < graph_edges; e++) begin
            if (graph_src[e] != u || graph_dst[e] >= n) continue;
            cand = du + graph_wt[e];
            if (cand > DIST_INF - 1) cand = DIST_INF - 1;
            if (cand < dist_tab[graph_dst[e]]) begin
               dist_tab[graph_dst[e]] = cand[20:0];
               par[graph_dst[e]] = u[5:0];
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         r = '0;
         r.node_index = i[5:0];
         r.reached = (dist_tab[i] != DIST_INF);
         r.path_length = r.reached ? dist_tab[i] : '0;
         r.tree_parent = r.reached ? par[i] : '0;
         r.last_result = (i == n - 1);
         expected_paths.push_back(r);
      end
   endtask

   // Shadow update for one accepted edge transaction.
   task automatic absorb_edge(input req_type t);
      rsp_type r;
      if (t.edge_weight < 0) graph_neg = 1;
      else if (graph_edges < EDGES_MAX) begin
         graph_src[graph_edges] = t.edge_from;
         graph_dst[graph_edges] = t.edge_to;
         graph_wt[graph_edges] = {5'd0, t.edge_weight};
         graph_edges++;
      end
      if (!t.last_edge) return;
      runs_done++;
      if (graph_neg) begin
         r = '0;
         r.neg_weight_error = 1'b1;
         r.last_result = 1'b1;
         expected_paths.push_back(r);
         error_runs++;
      end else predict_paths();
      graph_edges = 0;
      graph_neg = 0;
   endtask

   // Sender: valid held until the transaction is taken; dropped only for a gap.
   task automatic send_edge(input req_type t);
      int gap;
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (!req_ready);
      absorb_edge(t);
   endtask

   task automatic csr_write(input logic [0:0] idx, input logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_NODE_COUNT) cfg_nodes = val[6:0];
      else cfg_start = val[5:0];
   endtask

   // Wait for every outstanding result, then let the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_paths.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic req_type mk_edge(int f, int t, int w, bit l);
      req_type e;
      e.edge_from = f[5:0];
      e.edge_to = t[5:0];
      e.edge_weight = w[15:0];
      e.last_edge = l;
      return e;
   endfunction

   // Receiver: random stall per transaction, compare with the oldest expectation.
   initial begin : rsp_side
      rsp_type want;
      int gap;
      @(negedge reset);
      forever begin
         gap = $urandom_range(0, 8);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         results_seen++;
         if (expected_paths.size() == 0)
            report_mismatch($sformatf("unexpected result %p", rsp_data));
         else begin
            want = expected_paths.pop_front();
            if (rsp_data.node_index !== want.node_index)
               report_mismatch($sformatf("node_index %0d want %0d",
                  rsp_data.node_index, want.node_index));
            if (rsp_data.path_length !== want.path_length)
               report_mismatch($sformatf("node %0d path_length %0d want %0d",
                  want.node_index, rsp_data.path_length, want.path_length));
            if (rsp_data.reached !== want.reached)
               report_mismatch($sformatf("node %0d reached %b want %b",
                  want.node_index, rsp_data.reached, want.reached));
            if (rsp_data.tree_parent !== want.tree_parent)
               report_mismatch($sformatf("node %0d tree_parent %0d want %0d",
                  want.node_index, rsp_data.tree_parent, want.tree_parent));
            if (rsp_data.neg_weight_error !== want.neg_weight_error)
               report_mismatch($sformatf("node %0d neg_weight_error %b want %b",
                  want.node_index, rsp_data.neg_weight_error, want.neg_weight_error));
            if (rsp_data.last_result !== want.last_result)
               report_mismatch($sformatf("node %0d last_result %b want %b",
                  want.node_index, rsp_data.last_result, want.last_result));
         end
      end
   end

   // Directed table: one row per transaction; all groups run with the default config.
   typedef struct {
      int f, t, w;
      bit l;
   } edge_row;

   edge_row directed_rows[] = '{
      // default config: chain 0->1->2, with two parallel direct edges, one longer, one of equal length
      '{0, 1, 5, 0}, '{1, 2, 7, 0}, '{0, 2, 20, 0}, '{0, 2, 12, 1},
      // negative weight anywhere gives the error transaction
      '{0, 1, 3, 0}, '{2, 3, -32768, 0}, '{1, 4, 32767, 1},
      // large weights along a chain, plus edges from the unreachable nodes 63 and 62
      '{0, 1, 32767, 0}, '{1, 2, 32767, 0}, '{2, 3, 32767, 0},
      '{63, 62, 0, 0}, '{62, 0, 1, 1},
      // lone last edge, negative
      '{5, 5, -1, 1}
   };

   initial begin : stimulus
      req_type e;
      int n, len, k;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_edge(mk_edge(directed_rows[i].f, directed_rows[i].t,
                           directed_rows[i].w, directed_rows[i].l));
      drain();

      // Node count extremes and out-of-range start: 0 acts as 1, 127 as 64.
      csr_write(REG_NODE_COUNT, 32'd0);
      send_edge(mk_edge(0, 0, 4, 1));
      drain();
      csr_write(REG_NODE_COUNT, 32'd127);
      csr_write(REG_START_NODE, 32'd63);
      send_edge(mk_edge(63, 0, 9, 0));
      send_edge(mk_edge(0, 63, 1, 1));
      drain();
      csr_write(REG_NODE_COUNT, 32'd4);
      csr_write(REG_START_NODE, 32'd10);
      send_edge(mk_edge(0, 1, 1, 1));
      drain();
      csr_write(REG_START_NODE, 32'd2);
      send_edge(mk_edge(2, 9, 1, 0)); // endpoint beyond node count
      send_edge(mk_edge(2, 3, 0, 1));
      drain();

      // Full store: more edges than the store holds, those past its end dropped.
      csr_write(REG_NODE_COUNT, 32'd8);
      csr_write(REG_START_NODE, 32'd0);
      for (int i = 0; i < 260; i++)
         send_edge(mk_edge($urandom_range(0, 7), $urandom_range(0, 7),
                           $urandom_range(0, 32767), i == 259));
      drain();

      // Random graphs, mostly small node counts, mostly valid weights.
      k = 0;
      while (k < 120) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 12);
         csr_write(REG_NODE_COUNT, n);
         csr_write(REG_START_NODE, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                               : $urandom_range(0, n - 1));
         len = $urandom_range(1, 3 * n);
         for (int j = 0; j < len; j++) begin
            e.edge_from = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, n - 1));
            e.edge_to = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, n - 1));
            case ($urandom_range(0, 19))
               0: e.edge_weight = 16'($urandom);
               1: e.edge_weight = 16'h7fff;
               2: e.edge_weight = 16'h0000;
               default: e.edge_weight = 16'($urandom_range(0, 1000));
            endcase
            e.last_edge = (j == len - 1);
            send_edge(e);
            k++;
         end
         drain();
      end

      $display("Ran %0d searches (%0d error runs), %0d results checked.",
               runs_done, error_runs, results_seen);
      if (errors == 0)
         $display("** single_source_shortest_path_top: PASSED **");
      else
         $display("** single_source_shortest_path_top: FAILED **");
      $finish;
   end

   initial begin : watchdog
      #200ms;
      $display("Timeout with %0d results outstanding", expected_paths.size());
      $display("** single_source_shortest_path_top: FAILED **");
      $finish;
   end

endmodule

/* files.f */
rtl/core/sssp_pkg.sv
rtl/core/sssp_ctrl.sv
rtl/core/sssp_dpath.sv
rtl/core/single_source_shortest_path_top.sv
tb/sv/tb_single_source_shortest_path_top.sv
